### hdl/oale_pkg.sv
// Shared types and codes for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam int FIDX_W  = 5;
    localparam int COUNT_W = 6;

    // Request kinds
    localparam logic [1:0] REQ_FIND   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } oale_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIDX_W-1:0]  found_index;
        logic [COUNT_W-1:0] entry_count;
    } oale_rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      cmp_en;
    } cell_ctrl_t;

endpackage

### hdl/oale_cell.sv
// One storage cell of the list: holds a word, shifts with its neighbors, compares to a key.
`timescale 1ns / 1ps

module oale_cell (
    input  logic                         aclk,
    input  oale_pkg::cell_ctrl_t         ctrl,
    input  logic [oale_pkg::WORD_W-1:0]  cmp_key,
    input  logic [oale_pkg::WORD_W-1:0]  load_word,
    input  logic [oale_pkg::WORD_W-1:0]  left_word,
    input  logic [oale_pkg::WORD_W-1:0]  right_word,
    output logic [oale_pkg::WORD_W-1:0]  word,
    output logic                         match
);
    import oale_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              match_reg;
    logic              match_next;

    always_comb begin
        case (ctrl.cmd)
            CELL_LOAD:       word_next = load_word;
            CELL_FROM_LEFT:  word_next = left_word;
            CELL_FROM_RIGHT: word_next = right_word;
            default:         word_next = word_reg;
        endcase
        match_next = ctrl.cmp_en ? (word_reg == cmp_key) : match_reg;
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

### hdl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: request control, cell chain, result register.
//
// Usage: one request is a transfer on s_valid/s_ready carrying s_data (req_type, value,
// position); its single result is a transfer on m_valid/m_ready carrying m_data (status,
// found_index, entry_count). The list lives in a row of CAPACITY cells; insert shifts the
// tail up one cell, delete shifts it down, and every cell compares its word with the key.
// On the accept edge every cell registers its compare; in the execute step, once the result
// register is free, the cells shift or load, the count updates and the result lands in the
// output register. The control takes one request at a time: a new request is taken once the
// previous one has left the execute step.
// The result register lets the next request be accepted while a result still waits.
// If the receiver stalls with a result pending, the execute step holds until m_ready frees
// the register, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous): the list is empty, no result is pending and the block
// is ready at once. Cell contents are not cleared; only entries below the count are read.
`timescale 1ns / 1ps

module ordered_array_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oale_pkg::oale_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output oale_pkg::oale_rsp_t m_data
);
    import oale_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    oale_req_t         req_reg, req_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    oale_rsp_t         m_data_reg, m_data_next;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    cell_ctrl_t        cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0] hit;

    logic              s_fire;
    logic              advance;
    logic [PW-1:0]     pos_w, cnt_w, idx_w;
    logic              is_full;
    logic              ins_ok, del_ok;
    logic [IW-1:0]     find_idx;
    logic              any_hit;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign advance = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign pos_w   = PW'(req_reg.position);
    assign cnt_w   = PW'(count_reg);
    assign idx_w   = pos_w - PW'(1);
    assign is_full = (count_reg == CW'(CAPACITY));
    assign ins_ok  = (req_reg.req_type == REQ_INSERT) && !is_full &&
                     (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
    assign del_ok  = (req_reg.req_type == REQ_DELETE) &&
                     (pos_w != '0) && (pos_w <= cnt_w);

    // Cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (k == 0) begin : g_first
            assign left_w = cell_word[k];
        end else begin : g_mid_l
            assign left_w = cell_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_w = cell_word[k];
        end else begin : g_mid_r
            assign right_w = cell_word[k+1];
        end

        always_comb begin
            cell_ctrl[k].cmp_en = s_fire;
            cell_ctrl[k].cmd    = CELL_HOLD;
            if (advance && ins_ok) begin
                if (PW'(k) > idx_w) begin
                    cell_ctrl[k].cmd = CELL_FROM_LEFT;
                end else if (PW'(k) == idx_w) begin
                    cell_ctrl[k].cmd = CELL_LOAD;
                end
            end else if (advance && del_ok) begin
                if (PW'(k) >= idx_w) begin
                    cell_ctrl[k].cmd = CELL_FROM_RIGHT;
                end
            end
        end

        assign hit[k] = cell_match[k] && (PW'(k) < cnt_w);

        oale_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[k]),
            .cmp_key    (s_data.value),
            .load_word  (req_reg.value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[k]),
            .match      (cell_match[k])
        );
    end

    // Lowest matching cell wins
    always_comb begin
        find_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (hit[k]) begin
                find_idx = IW'(k);
            end
        end
    end
    assign any_hit = |hit;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next   = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (advance) begin
                    m_data_next.found_index = '0;
                    unique case (req_reg.req_type)
                        REQ_FIND: begin
                            if (any_hit) begin
                                m_data_next.status      = ST_OK;
                                m_data_next.found_index = FIDX_W'(find_idx);
                            end else begin
                                m_data_next.status = ST_NOTFOUND;
                            end
                        end
                        REQ_INSERT: begin
                            if (is_full) begin
                                m_data_next.status = ST_FULL;
                            end else if (ins_ok) begin
                                m_data_next.status = ST_OK;
                                count_next         = count_reg + CW'(1);
                            end else begin
                                m_data_next.status = ST_BADPOS;
                            end
                        end
                        REQ_DELETE: begin
                            if (del_ok) begin
                                m_data_next.status = ST_OK;
                                count_next         = count_reg - CW'(1);
                            end else begin
                                m_data_next.status = ST_BADPOS;
                            end
                        end
                        default: m_data_next.status = ST_BADPOS;
                    endcase
                    m_data_next.entry_count = COUNT_W'(count_next);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && m_valid_reg && !m_ready |=>
            (state_reg == ST_EXEC) && $stable(count_reg))
        else $error("execute step moved while result register was blocked");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg && (m_data_reg.entry_count == COUNT_W'(count_reg)))
        else $error("result entry count disagrees with list count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(count_reg))
        else $error("entry count changed outside execute step");
`endif

endmodule

### verif/oale_list_checker.sv
// Checker for the ordered array list engine: tracks the list, predicts each result and compares.
`timescale 1ns / 1ps

module oale_list_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  oale_pkg::oale_req_t s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  oale_pkg::oale_rsp_t m_data,
    output int                  mismatch_count,
    output int                  rsp_pending
);
    import oale_pkg::*;

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len = 0;
    oale_rsp_t                predicted_rsp [$];
    int                       fail_total = 0;

    initial begin
        mismatch_count = 0;
        rsp_pending    = 0;
    end

    // Apply one request to the tracked list and return the result it must produce.
    function automatic oale_rsp_t predict_list_op(input oale_req_t req);
        oale_rsp_t rsp;
        int        pos;
        bit        hit;
        rsp        = '0;
        rsp.status = ST_BADPOS;
        pos        = int'(req.position);
        hit        = 1'b0;
        case (req.req_type)
            REQ_FIND: begin
                rsp.status = ST_NOTFOUND;
                for (int k = 0; k < list_len; k++) begin
                    if (!hit && list_words[k] == req.value) begin
                        hit             = 1'b1;
                        rsp.status      = ST_OK;
                        rsp.found_index = FIDX_W'(k);
                    end
                end
            end
            REQ_INSERT: begin
                // fullness wins over a bad position
                if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (pos >= 1 && pos <= list_len + 1) begin
                    for (int k = list_len; k >= pos; k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[pos-1] = req.value;
                    list_len++;
                    rsp.status = ST_OK;
                end
            end
            REQ_DELETE: begin
                if (pos >= 1 && pos <= list_len) begin
                    for (int k = pos; k < list_len; k++) begin
                        list_words[k-1] = list_words[k];
                    end
                    list_len--;
                    rsp.status = ST_OK;
                end
            end
            default: ;
        endcase
        rsp.entry_count = COUNT_W'(list_len);
        return rsp;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        oale_rsp_t want;
        if (!aresetn) begin
            list_len = 0;
            predicted_rsp.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_rsp.size() == 0) begin
                    $display("%0t: result with none expected: status=%0d found_index=%0d entry_count=%0d",
                             $time, m_data.status, m_data.found_index, m_data.entry_count);
                    fail_total++;
                end else begin
                    want = predicted_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("found_index", 32'(want.found_index), 32'(m_data.found_index));
                    check_field("entry_count", 32'(want.entry_count), 32'(m_data.entry_count));
                end
            end
            if (s_valid && s_ready) begin
                predicted_rsp.push_back(predict_list_op(s_data));
            end
        end
        mismatch_count <= fail_total;
        rsp_pending    <= predicted_rsp.size();
    end

endmodule

### verif/ordered_array_list_engine_tb.sv
// Testbench top for the ordered array list engine: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module ordered_array_list_engine_tb;
    import oale_pkg::*;

    localparam int         CAPACITY     = 32;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_COUNT  = 8;
    localparam int         PHASE_REQS   = 128;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    oale_req_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    oale_rsp_t m_data;

    int mismatch_count;
    int rsp_pending;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int shadow_len     = 0;
    bit grow_mode      = 1'b1;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    ordered_array_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    oale_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .rsp_pending    (rsp_pending)
    );

    // Small pool of repeated words so finds hit, often with duplicates in the list.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            4:       return 32'sh0000_0005;
            5:       return 32'sh5A5A_A5A5;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input int hi);
        if (hi < 1 || $urandom_range(99) < 15) begin
            return POS_W'($urandom_range(63));
        end
        return POS_W'($urandom_range(hi, 1));
    endfunction

    // Alternate between filling the list up to full and draining it to empty.
    function automatic oale_req_t make_random_request();
        oale_req_t req;
        int        roll;
        if (grow_mode && shadow_len == CAPACITY && $urandom_range(3) == 0) begin
            grow_mode = 1'b0;
        end else if (!grow_mode && shadow_len == 0 && $urandom_range(3) == 0) begin
            grow_mode = 1'b1;
        end
        roll      = $urandom_range(99);
        req.value = pick_word();
        if (roll < 4) begin
            req.req_type = REQ_RESERVED;
            req.position = POS_W'($urandom_range(63));
        end else if (roll < 30) begin
            req.req_type = REQ_FIND;
            req.position = POS_W'($urandom_range(63));
        end else if ((roll < 85) == grow_mode) begin
            req.req_type = REQ_INSERT;
            req.position = pick_pos(shadow_len + 1);
        end else begin
            req.req_type = REQ_DELETE;
            req.position = pick_pos(shadow_len);
        end
        return req;
    endfunction

    task automatic send_request(input oale_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // keep the fill level so positions stay mostly in range
        case (req.req_type)
            REQ_INSERT: begin
                if (shadow_len < CAPACITY && req.position >= 1
                    && req.position <= shadow_len + 1) begin
                    shadow_len++;
                end
            end
            REQ_DELETE: begin
                if (req.position >= 1 && req.position <= shadow_len) begin
                    shadow_len--;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic signed [WORD_W-1:0] word,
                               input logic [POS_W-1:0] pos);
        oale_req_t req;
        req.req_type = kind;
        req.value    = word;
        req.position = pos;
        send_request(req);
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ordered_array_list_engine regression: fail");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list and out-of-range positions
        send_fields(REQ_FIND,   32'sh0000_0000, 6'd0);
        send_fields(REQ_DELETE, 32'sh0000_0000, 6'd1);
        send_fields(REQ_INSERT, 32'sh0000_0001, 6'd0);
        send_fields(REQ_INSERT, 32'sh0000_0001, 6'd2);
        // build 0, max, min, max, -1 with extremes and a duplicate
        send_fields(REQ_INSERT, 32'sh8000_0000, 6'd1);
        send_fields(REQ_INSERT, 32'sh7FFF_FFFF, 6'd2);
        send_fields(REQ_INSERT, 32'sh0000_0000, 6'd1);
        send_fields(REQ_INSERT, 32'shFFFF_FFFF, 6'd4);
        send_fields(REQ_INSERT, 32'sh7FFF_FFFF, 6'd2);
        send_fields(REQ_FIND,   32'sh7FFF_FFFF, 6'd63);
        send_fields(REQ_FIND,   32'sh8000_0000, 6'd0);
        send_fields(REQ_FIND,   32'shFFFF_FFFF, 6'd0);
        send_fields(REQ_FIND,   32'sh0001_2345, 6'd0);
        send_fields(REQ_INSERT, 32'sh0000_0007, 6'd63);
        send_fields(REQ_DELETE, 32'sh0000_0000, 6'd0);
        send_fields(REQ_DELETE, 32'sh0000_0000, 6'd6);
        send_fields(REQ_DELETE, 32'shFFFF_FFFF, 6'd5);
        send_fields(REQ_DELETE, 32'sh0000_0000, 6'd1);
        send_fields(REQ_RESERVED, 32'shFFFF_FFFF, 6'd63);
        send_fields(REQ_FIND,   32'sh0000_0000, 6'd0);
        send_fields(REQ_DELETE, 32'sh0000_0000, 6'd2);
        send_fields(REQ_FIND,   32'sh7FFF_FFFF, 6'd0);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 45; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 45; end
                default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
            endcase
            for (int n = 0; n < PHASE_REQS; n++) begin
                send_request(make_random_request());
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (rsp_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && rsp_pending == 0) begin
            $display("ordered_array_list_engine regression: pass");
        end else begin
            $display("ordered_array_list_engine regression: fail");
        end
        $finish;
    end

endmodule
